/* sv/ras_pkg.sv */
// Package for the recurring alarm scheduler: payload structs, entry layout,
// operation and repeat codes, divider interface types. No dependencies.
package ras_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned DAY_W     = 17;
  localparam int unsigned TIME_W    = 32;
  localparam logic [DAY_W-1:0] SPD_RESET = 17'd86400;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_DEL_SLOT = 2'd1;
  localparam logic [1:0] MODE_DEL_TIME = 2'd2;
  localparam logic [1:0] MODE_POP      = 2'd3;

  localparam logic [3:0] REP_ONCE    = 4'd0;
  localparam logic [3:0] REP_DAILY   = 4'd8;
  localparam logic [3:0] REP_WORK    = 4'd9;
  localparam logic [3:0] REP_WEEKEND = 4'd10;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] task_time;
    logic [3:0]        repeat_kind;
    logic [3:0]        action_code;
    logic              action_level;
    logic [3:0]        slot_id;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [3:0]        slot;
    logic [TIME_W-1:0] due_time;
    logic [3:0]        action_out;
    logic              level_out;
    logic [4:0]        entries;
    logic [TIME_W-1:0] head_time;
    logic              empty_res;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [3:0]        kind;
    logic [3:0]        act;
    logic              lvl;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [DAY_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DAY_W-1:0] rem;
    logic [2:0]       qmod7;
  } div_rsp_t;

endpackage

/* sv/ras_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ras_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/ras_div.sv */
// Serial restoring divider: 32-bit dividend by 17-bit divisor, one bit a cycle.
// Tracks the quotient modulo 7 alongside. Depends on ras_pkg.
module ras_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ras_pkg::div_req_t req_i,
  output ras_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW   = ras_pkg::TIME_W;
  localparam int unsigned RW   = ras_pkg::DAY_W;
  localparam int unsigned CNTW = $clog2(DW);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   dvd_q, dvd_d;
  logic [RW-1:0]   r_q, r_d, dsr_q, dsr_d;
  logic [2:0]      m_q, m_d;
  logic [RW:0]     r_sh;
  logic            ge;
  logic [3:0]      m_sh;

  always_comb begin
    r_sh   = {r_q, dvd_q[DW-1]};
    ge     = (r_sh >= {1'b0, dsr_q});
    m_sh   = {m_q, ge};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    r_d    = r_q;
    m_d    = m_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      r_d    = '0;
      m_d    = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract where it fits
      r_d   = ge ? RW'(r_sh - {1'b0, dsr_q}) : r_sh[RW-1:0];
      m_d   = (m_sh >= 4'd7) ? 3'(m_sh - 4'd7) : m_sh[2:0];
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      cnt_d = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    r_q   <= r_d;
    m_q   <= m_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.rem   = r_q;
  assign rsp_o.qmod7 = m_q;

endmodule

/* sv/recurring_alarm_scheduler_core.sv */
// Top level of the recurring alarm scheduler: sequencer, slot flags, order
// and entry memories. Depends on ras_pkg, ras_ram and ras_div.
//
//  channel | direction | signals                          | payload
//  --------+-----------+----------------------------------+----------------
//  in      | sink      | in_valid_i / in_ready_o          | ras_pkg::in_t
//  out     | source    | out_valid_o / out_ready_i        | ras_pkg::out_t
//  cfg     | sink      | cfg_valid_i / cfg_ready_o        | seconds_per_day
//
// Operations: one at a time. A failed pop or delete by slot goes straight to the
// head fetch and the result stage. Delete by slot reads the entry, walks the order
// list and moves later entries up; delete by time scans the slots, then walks the
// list. Add and pop end with an insertion that shifts later entries from the tail;
// a rescheduled weekday or weekly entry adds two serial divisions and the offset
// arithmetic, so the worst case is a pop of a weekly entry put back at the front of a full list.
// The serial divider and the one-port-each order and entry memories set the running time.
// Reset: slot flags and list length clear at once; no clearing pass.
// Stalls: a held result parks in the output register while the next transfer
// is taken; the result stage waits only when a second result is ready.
module recurring_alarm_scheduler_core #(
  parameter int unsigned SLOTS = ras_pkg::SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ras_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ras_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ras_pkg::DAY_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned TW = ras_pkg::TIME_W;
  localparam int unsigned DW = ras_pkg::DAY_W;
  localparam int unsigned EW = $bits(ras_pkg::entry_t);
  localparam int unsigned NS = 28;

  typedef enum logic [NS-1:0] {
    ST_IDLE  = 28'b1 << 0,
    ST_FREE  = 28'b1 << 1,
    ST_TRD   = 28'b1 << 2,
    ST_TCMP  = 28'b1 << 3,
    ST_SRD   = 28'b1 << 4,
    ST_WRD   = 28'b1 << 5,
    ST_WCHK  = 28'b1 << 6,
    ST_WEND  = 28'b1 << 7,
    ST_PGET  = 28'b1 << 8,
    ST_DN0   = 28'b1 << 9,
    ST_DN1   = 28'b1 << 10,
    ST_DH0   = 28'b1 << 11,
    ST_DH1   = 28'b1 << 12,
    ST_CALC  = 28'b1 << 13,
    ST_MUL   = 28'b1 << 14,
    ST_ADD   = 28'b1 << 15,
    ST_EWR   = 28'b1 << 16,
    ST_IRD   = 28'b1 << 17,
    ST_IWT   = 28'b1 << 18,
    ST_ICMP  = 28'b1 << 19,
    ST_IPUT  = 28'b1 << 20,
    ST_HEAD0 = 28'b1 << 21,
    ST_HEAD1 = 28'b1 << 22,
    ST_HEAD2 = 28'b1 << 23,
    ST_OUT   = 28'b1 << 24,
    ST_FRD   = 28'b1 << 25,
    ST_FWT   = 28'b1 << 26,
    ST_FCMP  = 28'b1 << 27
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [SLOTS-1:0] used_q, used_d;
  logic [LW-1:0]    len_q, len_d;
  logic             outv_q, outv_d;
  logic [DW-1:0]    spd_q;

  // operation context
  ras_pkg::in_t  req_q, req_d;
  ras_pkg::out_t out_q, out_d;
  logic [LW-1:0] s_q, s_d, i_q, i_d, j_q, j_d;
  logic [SW-1:0] slot_q, slot_d, target_q, target_d, o_q, o_d;
  logic          found_q, found_d, ok_q, ok_d, front_q, front_d;
  logic [TW-1:0] due_q, due_d, rdue_q, rdue_d, head_q, head_d;
  logic [TW-1:0] base_q, base_d, sum_q, sum_d;
  logic [3:0]    kind_q, kind_d, act_q, act_d, off_q, off_d;
  logic          lvl_q, lvl_d;
  logic [DW-1:0] tod_q, tod_d, hit_q, hit_d;
  logic [2:0]    qm_q, qm_d;
  logic [DW+3:0] prod_q, prod_d;

  // memories
  logic          ord_we;
  logic [SW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rd;
  logic          ent_we;
  logic [SW-1:0] ent_waddr, ent_raddr;
  ras_pkg::entry_t ent_wdata, ent_rd;

  ras_pkg::div_req_t div_req;
  ras_pkg::div_rsp_t div_rsp;

  // helpers
  logic [DW-1:0]   d_eff;
  logic [TW-1:0]   d32, d7;
  logic [SW+3:0]   sid_ext, slot_ext;
  logic [LW+4:0]   len_ext;
  logic            sid_ok, is_pop, is_add, recur, shift;
  logic [LW-1:0]   i_p1, j_m1;
  logic [SW-1:0]   i_m1;
  logic [2:0]      today;
  logic [3:0]      t3;
  logic [3:0]      dd, woff, off_c;
  logic            late;
  logic signed [4:0] nd;

  ras_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rd)
  );

  ras_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd)
  );

  ras_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // a day length of zero counts as one
  assign d_eff = (spd_q == '0) ? DW'(1) : spd_q;
  assign d32   = {{(TW - DW){1'b0}}, d_eff};
  assign d7    = TW'({d_eff, 3'b000}) - d32;

  assign sid_ext  = {{SW{1'b0}}, in_data_i.slot_id};
  assign sid_ok   = (32'(in_data_i.slot_id) < SLOTS) && used_q[sid_ext[SW-1:0]];
  assign is_pop   = (req_q.mode == ras_pkg::MODE_POP);
  assign is_add   = (req_q.mode == ras_pkg::MODE_ADD);
  assign recur    = (req_q.repeat_kind != ras_pkg::REP_ONCE) &&
                    (req_q.repeat_kind != ras_pkg::REP_DAILY);
  assign i_p1     = i_q + LW'(1);
  assign i_m1     = i_q[SW-1:0] - SW'(1);
  assign j_m1     = j_q - LW'(1);
  assign slot_ext = {4'b0000, slot_q};
  assign len_ext  = {5'b00000, len_q};

  assign div_req.start    = (state_q == ST_DN0) || (state_q == ST_DH0);
  assign div_req.dividend = (state_q == ST_DN0) ? req_q.now : due_q;
  assign div_req.divisor  = d_eff;

  // weekday of now, then the day offset of the next matching day
  always_comb begin
    t3    = {1'b0, qm_q} + 4'd3;
    today = 3'((t3 >= 4'd7) ? (t3 - 4'd7) : t3) + 3'd1;
    late  = (hit_q <= tod_q);
    woff  = 4'd0;
    for (int k = 6; k >= 0; k--) begin
      dd = {1'b0, today} - 4'd1 + 4'(k);
      dd = ((dd >= 4'd7) ? (dd - 4'd7) : dd) + 4'd1;
      if (!((k == 0) && late)) begin
        if (((kind_q == ras_pkg::REP_WORK) && (dd >= 4'd1) && (dd <= 4'd5)) ||
            ((kind_q == ras_pkg::REP_WEEKEND) && (dd >= 4'd6) && (dd <= 4'd7))) begin
          woff = 4'(k);
        end
      end
    end
    nd = $signed({1'b0, kind_q}) - $signed({2'b00, today});
    if (!((nd > 5'sd0) || ((nd == 5'sd0) && !late))) begin
      nd = nd + 5'sd7;
    end
    if ((kind_q == ras_pkg::REP_WORK) || (kind_q == ras_pkg::REP_WEEKEND)) begin
      off_c = woff;
    end else begin
      off_c = nd[3:0];
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    len_d    = len_q;
    outv_d   = outv_q;
    req_d    = req_q;
    out_d    = out_q;
    s_d      = s_q;
    i_d      = i_q;
    j_d      = j_q;
    slot_d   = slot_q;
    target_d = target_q;
    o_d      = o_q;
    found_d  = found_q;
    ok_d     = ok_q;
    front_d  = front_q;
    due_d    = due_q;
    rdue_d   = rdue_q;
    head_d   = head_q;
    base_d   = base_q;
    sum_d    = sum_q;
    kind_d   = kind_q;
    act_d    = act_q;
    lvl_d    = lvl_q;
    off_d    = off_q;
    tod_d    = tod_q;
    hit_d    = hit_q;
    qm_d     = qm_q;
    prod_d   = prod_q;
    shift    = 1'b0;

    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    ord_raddr = '0;
    ent_we    = 1'b0;
    ent_waddr = '0;
    ent_wdata = '0;
    ent_raddr = '0;

    if (outv_q && out_ready_i) begin
      outv_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          ok_d    = 1'b0;
          found_d = 1'b0;
          i_d     = '0;
          s_d     = '0;
          case (in_data_i.mode)
            ras_pkg::MODE_ADD: begin
              state_d = ST_FREE;
            end
            ras_pkg::MODE_DEL_SLOT: begin
              if (sid_ok) begin
                used_d[sid_ext[SW-1:0]] = 1'b0;
                ent_raddr = sid_ext[SW-1:0];
                target_d  = sid_ext[SW-1:0];
                state_d   = ST_SRD;
              end else begin
                state_d = ST_HEAD0;
              end
            end
            ras_pkg::MODE_DEL_TIME: begin
              state_d = ST_TRD;
            end
            default: begin
              state_d = (len_q != '0) ? ST_WRD : ST_HEAD0;
            end
          endcase
        end
      end
      // lowest free slot, one flag a cycle
      ST_FREE: begin
        if (s_q == LW'(SLOTS)) begin
          state_d = ST_HEAD0;
        end else if (!used_q[s_q[SW-1:0]]) begin
          used_d[s_q[SW-1:0]] = 1'b1;
          slot_d  = s_q[SW-1:0];
          due_d   = req_q.task_time;
          kind_d  = req_q.repeat_kind;
          act_d   = req_q.action_code;
          lvl_d   = req_q.action_level;
          state_d = recur ? ST_DN0 : ST_EWR;
        end else begin
          s_d = s_q + LW'(1);
        end
      end
      ST_TRD: begin
        ent_raddr = s_q[SW-1:0];
        state_d   = ST_TCMP;
      end
      ST_TCMP: begin
        if (used_q[s_q[SW-1:0]] && (ent_rd.due == req_q.task_time)) begin
          used_d[s_q[SW-1:0]] = 1'b0;
          ok_d     = 1'b1;
          slot_d   = s_q[SW-1:0];
          target_d = s_q[SW-1:0];
          rdue_d   = req_q.task_time;
          state_d  = ST_WRD;
        end else if (s_q == LW'(SLOTS - 1)) begin
          state_d = ST_HEAD0;
        end else begin
          s_d     = s_q + LW'(1);
          state_d = ST_TRD;
        end
      end
      ST_SRD: begin
        rdue_d  = ent_rd.due;
        slot_d  = target_q;
        state_d = ST_WRD;
      end
      // walk the order list; once the slot is found, move the rest up by one
      ST_WRD: begin
        ord_raddr = i_q[SW-1:0];
        state_d   = ST_WCHK;
      end
      ST_WCHK: begin
        if (found_q) begin
          ord_we    = 1'b1;
          ord_waddr = i_m1;
          ord_wdata = ord_rd;
        end else if ((is_pop && (i_q == '0)) || (ord_rd == target_q)) begin
          found_d = 1'b1;
          slot_d  = ord_rd;
        end
        i_d     = i_p1;
        state_d = (i_p1 == len_q) ? ST_WEND : ST_WRD;
      end
      ST_WEND: begin
        if (found_q) begin
          len_d = len_q - LW'(1);
        end
        if (is_pop) begin
          ok_d      = 1'b1;
          ent_raddr = slot_q;
          state_d   = ST_PGET;
        end else begin
          if (req_q.mode == ras_pkg::MODE_DEL_SLOT) begin
            ok_d = found_q;
          end
          state_d = ST_HEAD0;
        end
      end
      // popped entry: free it or advance its due time
      ST_PGET: begin
        rdue_d = ent_rd.due;
        act_d  = ent_rd.act;
        lvl_d  = ent_rd.lvl;
        kind_d = ent_rd.kind;
        case (ent_rd.kind)
          ras_pkg::REP_ONCE: begin
            used_d[slot_q] = 1'b0;
            state_d = ST_HEAD0;
          end
          ras_pkg::REP_DAILY: begin
            due_d   = ent_rd.due + d32;
            state_d = ST_EWR;
          end
          ras_pkg::REP_WORK, ras_pkg::REP_WEEKEND: begin
            due_d   = ent_rd.due + d32;
            state_d = ST_DN0;
          end
          default: begin
            due_d   = ent_rd.due + d7;
            state_d = ST_DN0;
          end
        endcase
      end
      ST_DN0: begin
        state_d = ST_DN1;
      end
      ST_DN1: begin
        if (div_rsp.done) begin
          qm_d    = div_rsp.qmod7;
          tod_d   = div_rsp.rem;
          state_d = ST_DH0;
        end
      end
      ST_DH0: begin
        state_d = ST_DH1;
      end
      ST_DH1: begin
        if (div_rsp.done) begin
          hit_d   = div_rsp.rem;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        off_d   = off_c;
        base_d  = req_q.now - {{(TW - DW){1'b0}}, tod_q};
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = off_q * d_eff;
        sum_d   = base_q + {{(TW - DW){1'b0}}, hit_q};
        state_d = ST_ADD;
      end
      ST_ADD: begin
        due_d   = sum_q + {{(TW - DW - 4){1'b0}}, prod_q};
        state_d = ST_EWR;
      end
      ST_EWR: begin
        ent_we         = 1'b1;
        ent_waddr      = slot_q;
        ent_wdata.due  = due_q;
        ent_wdata.kind = kind_q;
        ent_wdata.act  = act_q;
        ent_wdata.lvl  = lvl_q;
        if (is_add) begin
          ok_d   = 1'b1;
          rdue_d = due_q;
        end
        j_d     = len_q;
        state_d = (len_q == '0) ? ST_IPUT : ST_FRD;
      end
      // fetch the head's due time: at or before it, the entry goes to the front
      ST_FRD: begin
        ord_raddr = '0;
        state_d   = ST_FWT;
      end
      ST_FWT: begin
        ent_raddr = ord_rd;
        state_d   = ST_FCMP;
      end
      ST_FCMP: begin
        front_d   = (due_q <= ent_rd.due);
        ord_raddr = j_m1[SW-1:0];
        state_d   = ST_IWT;
      end
      // insertion from the tail: shift later entries down one place
      ST_IRD: begin
        ord_raddr = j_m1[SW-1:0];
        state_d   = ST_IWT;
      end
      ST_IWT: begin
        o_d       = ord_rd;
        ent_raddr = ord_rd;
        state_d   = ST_ICMP;
      end
      ST_ICMP: begin
        // a front insertion shifts every entry, equal times included
        shift = front_q || (ent_rd.due > due_q);
        if (shift) begin
          ord_we    = 1'b1;
          ord_waddr = j_q[SW-1:0];
          ord_wdata = o_q;
          j_d       = j_m1;
          state_d   = (j_q == LW'(1)) ? ST_IPUT : ST_IRD;
        end else begin
          state_d = ST_IPUT;
        end
      end
      ST_IPUT: begin
        ord_we    = 1'b1;
        ord_waddr = j_q[SW-1:0];
        ord_wdata = slot_q;
        len_d     = len_q + LW'(1);
        state_d   = ST_HEAD0;
      end
      // fetch the head's due time for the status fields
      ST_HEAD0: begin
        if (len_q == '0) begin
          head_d  = '0;
          state_d = ST_OUT;
        end else begin
          ord_raddr = '0;
          state_d   = ST_HEAD1;
        end
      end
      ST_HEAD1: begin
        ent_raddr = ord_rd;
        state_d   = ST_HEAD2;
      end
      ST_HEAD2: begin
        head_d  = ent_rd.due;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register is free
        if (!outv_q || out_ready_i) begin
          outv_d           = 1'b1;
          out_d.ok         = ok_q;
          out_d.slot       = ok_q ? slot_ext[3:0] : 4'd0;
          out_d.due_time   = ok_q ? rdue_q : '0;
          out_d.action_out = (ok_q && is_pop) ? act_q : 4'd0;
          out_d.level_out  = ok_q && is_pop && lvl_q;
          out_d.entries    = len_ext[4:0];
          out_d.head_time  = head_q;
          out_d.empty_res  = (len_q == '0);
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      len_q   <= '0;
      outv_q  <= 1'b0;
      spd_q   <= ras_pkg::SPD_RESET;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      len_q   <= len_d;
      outv_q  <= outv_d;
      if (cfg_valid_i) begin
        spd_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    out_q    <= out_d;
    s_q      <= s_d;
    i_q      <= i_d;
    j_q      <= j_d;
    slot_q   <= slot_d;
    target_q <= target_d;
    o_q      <= o_d;
    found_q  <= found_d;
    ok_q     <= ok_d;
    front_q  <= front_d;
    due_q    <= due_d;
    rdue_q   <= rdue_d;
    head_q   <= head_d;
    base_q   <= base_d;
    sum_q    <= sum_d;
    kind_q   <= kind_d;
    act_q    <= act_d;
    lvl_q    <= lvl_d;
    off_q    <= off_d;
    tod_q    <= tod_d;
    hit_q    <= hit_d;
    qm_q     <= qm_d;
    prod_q   <= prod_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // listed entries and claimed slots agree between operations
  a_len_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(used_q) == 32'(len_q)))
    else $error("list length differs from claimed slot count");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= SLOTS)
    else $error("list length beyond table size");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == ST_DN1) || (state_q == ST_DH1)))
    else $error("divider finished while nobody waited");

  a_out_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!outv_q || out_ready_i)) |=> (outv_q && state_q == ST_IDLE))
    else $error("result not loaded on leaving the result stage");

endmodule
